### src/qadd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qadd_pkg
// Shared types, register indexes and helpers for the quantized int8 adder.
// ----------------------------------------------------------------------------
package qadd_pkg;

   // Register file layout
   localparam int CSR_INDEX_W = 3;
   localparam int SETTINGS_W  = 51;
   localparam int CSR_DATA_W  = SETTINGS_W;

   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_OPERAND  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_OPERAND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COMMON_SHIFT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CLAMP_LOW      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CLAMP_HIGH     = 3'd5;

   // Reset values
   localparam logic [SETTINGS_W-1:0] SETTINGS_RESET     = '0;
   localparam logic [4:0]            COMMON_SHIFT_RESET = 5'd20;
   localparam logic signed [7:0]     CLAMP_LOW_RESET    = -8'sd128;
   localparam logic signed [7:0]     CLAMP_HIGH_RESET   = 8'sd127;

   // Lane counts of the two rescale units
   localparam int OPERAND_LANES = 2;
   localparam int OUTPUT_LANES  = 1;

   // Register stages from request to response
   localparam int PIPE_DEPTH = 9;

   // One set of scaling settings as laid out in a 51-bit register
   typedef struct packed {
      logic [4:0]          rshift;
      logic [4:0]          lshift;
      logic signed [8:0]   zero;
      logic signed [31:0]  mult;
   } scale_settings_type;

   function automatic scale_settings_type unpack_settings(
      input logic [SETTINGS_W-1:0] raw
   );
      scale_settings_type s;
      s.mult   = raw[31:0];
      s.zero   = raw[40:32];
      s.lshift = raw[45:41];
      s.rshift = raw[50:46];
      return s;
   endfunction

   // Left shift with 32-bit wrap; a shift of 32 or more clears the word
   function automatic logic [31:0] wrap_shl(
      input logic [31:0] value,
      input logic [5:0]  amount
   );
      logic [31:0] res;
      res = amount[5] ? 32'd0 : (value << amount[4:0]);
      return res;
   endfunction

endpackage

### src/qadd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qadd_req_if
// Request channel: two int8 operands and the end-of-tensor marker.
// ----------------------------------------------------------------------------
interface qadd_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] operand_a;
   logic signed [7:0] operand_b;
   logic              end_of_tensor;

   modport source(output valid, output operand_a, output operand_b,
                  output end_of_tensor, input ready);
   modport sink(input valid, input operand_a, input operand_b,
                input end_of_tensor, output ready);
endinterface

### src/qadd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qadd_rsp_if
// Response channel: requantized int8 sum and the end-of-tensor marker.
// ----------------------------------------------------------------------------
interface qadd_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] sum_out;
   logic              end_of_tensor_out;

   modport source(output valid, output sum_out, output end_of_tensor_out,
                  input ready);
   modport sink(input valid, input sum_out, input end_of_tensor_out,
                output ready);
endinterface

### src/qadd_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qadd_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qadd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [qadd_pkg::CSR_INDEX_W-1:0]  index;
   logic [qadd_pkg::CSR_DATA_W-1:0]   data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

### src/qadd_rescale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qadd_rescale
// Three-stage fixed-point rescale: saturating rounding doubling high
// multiply, then a rounding right shift (halves away from zero), per lane.
// ----------------------------------------------------------------------------
module qadd_rescale #(
   parameter int LANES = qadd_pkg::OPERAND_LANES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [31:0]            in_value [LANES],
   input  logic                          in_tag,
   input  qadd_pkg::scale_settings_type  settings [LANES],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [31:0]            out_value [LANES],
   output logic                          out_tag
);

   localparam logic signed [31:0] INT_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] INT_MIN   = 32'sh8000_0000;
   localparam logic signed [63:0] NUDGE_POS = 64'sd1 <<< 30;
   localparam logic signed [63:0] NUDGE_NEG = 64'sd1 - (64'sd1 <<< 30);
   localparam logic signed [63:0] TRUNC_BIAS = 64'sd2147483647;

   // Stage valids and per-stage advance
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   assign rdy3     = ~v3_ff | out_ready;
   assign rdy2     = ~v2_ff | rdy3;
   assign rdy1     = ~v1_ff | rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: full product and the overflow corner
   logic signed [63:0] prod_in [LANES];
   logic signed [63:0] prod_ff [LANES];
   logic               sat_in  [LANES];
   logic               sat_ff  [LANES];
   logic               tag1_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         prod_in[l] = in_value[l] * settings[l].mult;
         sat_in[l]  = (in_value[l] == INT_MIN) && (settings[l].mult == INT_MIN);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         prod_ff <= prod_in;
         sat_ff  <= sat_in;
         tag1_ff <= in_tag;
      end
   end

   // Stage 2: add nudge, divide by 2^31 truncating toward zero
   logic signed [31:0] high_in [LANES];
   logic signed [31:0] high_ff [LANES];
   logic               tag2_ff;

   always_comb begin
      logic signed [63:0] q;
      logic signed [63:0] d;
      for (int l = 0; l < LANES; l++) begin
         q = prod_ff[l] + (prod_ff[l][63] ? NUDGE_NEG : NUDGE_POS);
         d = (q + (q[63] ? TRUNC_BIAS : 64'sd0)) >>> 31;
         high_in[l] = sat_ff[l] ? INT_MAX : d[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         high_ff <= high_in;
         tag2_ff <= tag1_ff;
      end
   end

   // Stage 3: rounding right shift, halves away from zero
   logic signed [31:0] round_in [LANES];
   logic signed [31:0] round_ff [LANES];
   logic               tag3_ff;

   always_comb begin
      logic [31:0]        mask;
      logic [31:0]        rem;
      logic [31:0]        thr;
      logic signed [31:0] fl;
      for (int l = 0; l < LANES; l++) begin
         mask = (32'd1 << settings[l].rshift) - 32'd1;
         rem  = high_ff[l] & mask;
         thr  = {1'b0, mask[31:1]} + {31'd0, high_ff[l][31]};
         fl   = high_ff[l] >>> settings[l].rshift;
         round_in[l] = fl + ((rem > thr) ? 32'sd1 : 32'sd0);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         round_ff <= round_in;
         tag3_ff  <= tag2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_value = round_ff;
   assign out_tag   = tag3_ff;

endmodule

### src/quantized_int8_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_int8_add
// Requantizing element-wise add of two int8 streams, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req carries operand_a, operand_b and end_of_tensor; rsp returns sum_out
//   and end_of_tensor_out, one response per request, in request order. For
//   a scalar-broadcast add, repeat the scalar on operand_b.
//   csr writes one of six registers (index 0..5); other indexes are dropped.
//   csr is always ready; write it only while no request is in flight.
// Timing:
//   Nine register stages: operand prep, three-stage operand rescale, sum
//   and output shift, three-stage output rescale, zero point and clamp.
//   A request passes the stages in that order and shows on rsp from the
//   clamp stage register. One request per cycle is sustained while rsp
//   is ready; the 32x32 multiply stages set the clock period.
// Flow control:
//   Each stage holds its item until the next stage frees up, so a stalled
//   rsp fills the bubbles first and req drops ready only when all nine
//   stages are full. Nothing is lost or repeated under stall.
// Reset:
//   Synchronous, active high. Clears all stage valids and loads register
//   defaults (common shift 20, clamp range -128..127, others zero).
// ----------------------------------------------------------------------------
module quantized_int8_add (
   input  logic         clock,
   input  logic         reset,
   qadd_req_if.sink     req,
   qadd_rsp_if.source   rsp,
   qadd_csr_if.sink     csr
);

   // Configuration registers
   logic [qadd_pkg::SETTINGS_W-1:0] first_ff, second_ff, output_ff;
   logic [4:0]                      common_ff;
   logic signed [7:0]               clamp_low_ff, clamp_high_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff      <= qadd_pkg::SETTINGS_RESET;
         second_ff     <= qadd_pkg::SETTINGS_RESET;
         output_ff     <= qadd_pkg::SETTINGS_RESET;
         common_ff     <= qadd_pkg::COMMON_SHIFT_RESET;
         clamp_low_ff  <= qadd_pkg::CLAMP_LOW_RESET;
         clamp_high_ff <= qadd_pkg::CLAMP_HIGH_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            qadd_pkg::REG_FIRST_OPERAND:  first_ff      <= csr.data;
            qadd_pkg::REG_SECOND_OPERAND: second_ff     <= csr.data;
            qadd_pkg::REG_OUTPUT:         output_ff     <= csr.data;
            qadd_pkg::REG_COMMON_SHIFT:   common_ff     <= csr.data[4:0];
            qadd_pkg::REG_CLAMP_LOW:      clamp_low_ff  <= csr.data[7:0];
            qadd_pkg::REG_CLAMP_HIGH:     clamp_high_ff <= csr.data[7:0];
            default: ;
         endcase
      end
   end

   qadd_pkg::scale_settings_type first_set, second_set, output_set;
   assign first_set  = qadd_pkg::unpack_settings(first_ff);
   assign second_set = qadd_pkg::unpack_settings(second_ff);
   assign output_set = qadd_pkg::unpack_settings(output_ff);

   // Stage 0: add zero offsets, shift left with wrap
   logic               s0_v_ff;
   logic               s0_ready;
   logic               op_in_ready;
   logic signed [31:0] s0_val_in [qadd_pkg::OPERAND_LANES];
   logic signed [31:0] s0_val_ff [qadd_pkg::OPERAND_LANES];
   logic               s0_eot_ff;

   assign s0_ready  = ~s0_v_ff | op_in_ready;
   assign req.ready = s0_ready;

   always_comb begin
      logic signed [9:0] xa, xb;
      logic [5:0]        sha, shb;
      xa  = {{2{req.operand_a[7]}}, req.operand_a} + {first_set.zero[8], first_set.zero};
      xb  = {{2{req.operand_b[7]}}, req.operand_b} + {second_set.zero[8], second_set.zero};
      sha = {1'b0, common_ff} + {1'b0, first_set.lshift};
      shb = {1'b0, common_ff} + {1'b0, second_set.lshift};
      s0_val_in[0] = qadd_pkg::wrap_shl({{22{xa[9]}}, xa}, sha);
      s0_val_in[1] = qadd_pkg::wrap_shl({{22{xb[9]}}, xb}, shb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_v_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s0_val_ff <= s0_val_in;
         s0_eot_ff <= req.end_of_tensor;
      end
   end

   // Stages 1-3: operand rescale, both lanes side by side
   qadd_pkg::scale_settings_type op_set [qadd_pkg::OPERAND_LANES];
   logic signed [31:0]           op_out [qadd_pkg::OPERAND_LANES];
   logic                         op_out_valid;
   logic                         op_out_eot;
   logic                         s4_ready;

   assign op_set[0] = first_set;
   assign op_set[1] = second_set;

   qadd_rescale #(
      .LANES(qadd_pkg::OPERAND_LANES)
   ) u_op_rescale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_v_ff),
      .in_ready  (op_in_ready),
      .in_value  (s0_val_ff),
      .in_tag    (s0_eot_ff),
      .settings  (op_set),
      .out_valid (op_out_valid),
      .out_ready (s4_ready),
      .out_value (op_out),
      .out_tag   (op_out_eot)
   );

   // Stage 4: wrapped sum, output left shift
   logic               s4_v_ff;
   logic               out_in_ready;
   logic signed [31:0] s4_val_in;
   logic signed [31:0] s4_val_ff [qadd_pkg::OUTPUT_LANES];
   logic               s4_eot_ff;

   assign s4_ready = ~s4_v_ff | out_in_ready;

   always_comb begin
      logic [31:0] sum;
      sum       = op_out[0] + op_out[1];
      s4_val_in = qadd_pkg::wrap_shl(sum, {1'b0, output_set.lshift});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_v_ff <= op_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_val_ff[0] <= s4_val_in;
         s4_eot_ff    <= op_out_eot;
      end
   end

   // Stages 5-7: output rescale
   qadd_pkg::scale_settings_type out_set [qadd_pkg::OUTPUT_LANES];
   logic signed [31:0]           out_val [qadd_pkg::OUTPUT_LANES];
   logic                         out_valid;
   logic                         out_eot;
   logic                         s8_ready;

   assign out_set[0] = output_set;

   qadd_rescale #(
      .LANES(qadd_pkg::OUTPUT_LANES)
   ) u_out_rescale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_v_ff),
      .in_ready  (out_in_ready),
      .in_value  (s4_val_ff),
      .in_tag    (s4_eot_ff),
      .settings  (out_set),
      .out_valid (out_valid),
      .out_ready (s8_ready),
      .out_value (out_val),
      .out_tag   (out_eot)
   );

   // Stage 8: output zero point and activation clamp
   logic              rsp_valid_ff;
   logic signed [7:0] sum_in, sum_ff;
   logic              eot_ff;

   assign s8_ready = ~rsp_valid_ff | rsp.ready;

   always_comb begin
      logic signed [31:0] r;
      logic signed [31:0] lo, hi;
      r  = out_val[0] + {{23{output_set.zero[8]}}, output_set.zero};
      lo = {{24{clamp_low_ff[7]}}, clamp_low_ff};
      hi = {{24{clamp_high_ff[7]}}, clamp_high_ff};
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      sum_in = r[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s8_ready) begin
         rsp_valid_ff <= out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s8_ready) begin
         sum_ff <= sum_in;
         eot_ff <= out_eot;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.sum_out           = sum_ff;
   assign rsp.end_of_tensor_out = eot_ff;

endmodule

### src/qadd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qadd_checker
// Port-level checks on the quantized int8 adder: response handshake and
// request/response accounting against the pipeline depth.
// ----------------------------------------------------------------------------
module qadd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [7:0] rsp_sum_out,
   input logic              rsp_end_of_tensor_out
);

   localparam logic [3:0] DEPTH = 4'(qadd_pkg::PIPE_DEPTH);

   logic       req_acc, rsp_acc;
   logic [3:0] pending_ff;
   logic [3:0] pending_in;

   assign req_acc = req_valid & req_ready;
   assign rsp_acc = rsp_valid & rsp_ready;

   // Requests in flight
   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) pending_in = pending_ff + 4'd1;
      if (!req_acc && rsp_acc) pending_in = pending_ff - 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 4'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A response is only ever shown for a request taken earlier
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response without an outstanding request");

   // The pipeline never holds more requests than it has stages
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= DEPTH)
      else $error("more requests in flight than pipeline stages");

   // Nothing shows on the response side straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sum_out) && $stable(rsp_end_of_tensor_out))
      else $error("response payload changed while stalled");

endmodule

bind quantized_int8_add qadd_checker u_qadd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req.valid),
   .req_ready             (req.ready),
   .rsp_valid             (rsp.valid),
   .rsp_ready             (rsp.ready),
   .rsp_sum_out           (rsp.sum_out),
   .rsp_end_of_tensor_out (rsp.end_of_tensor_out)
);

### tb/quantized_int8_add_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_int8_add_tb
// Self-checking bench for the requantizing int8 adder. A table of directed
// requests covers the reset state, operand and setting extremes, saturation,
// shift wrap and a crossed clamp range. Random tensors, some broadcast, then
// run under several random register settings. Every response is compared
// with a typed-in sum or a bit-exact fixed-point model of the datapath. The
// sender idles in bursts, the receiver stalls on a changing pattern, and one
// long receiver stall fills the pipeline.
// ----------------------------------------------------------------------------
module quantized_int8_add_tb;

   localparam int CLOCK_PERIOD      = 20;
   localparam int RESET_CYCLES      = 10;
   localparam int CYCLE_LIMIT       = 200000;
   localparam int LONG_STALL_CYCLES = 200;
   localparam int RANDOM_PHASES     = 7;
   localparam int ITEMS_PER_PHASE   = 90;
   localparam int SETUP_COUNT       = 9;
   localparam int DIRECTED_COUNT    = 21;
   localparam int UNMAPPED_FIRST    = int'(qadd_pkg::REG_CLAMP_HIGH) + 1;
   localparam int UNMAPPED_LAST     = (1 << qadd_pkg::CSR_INDEX_W) - 1;

   // One full register setting
   typedef struct packed {
      logic [qadd_pkg::SETTINGS_W-1:0] first;
      logic [qadd_pkg::SETTINGS_W-1:0] second;
      logic [qadd_pkg::SETTINGS_W-1:0] outs;
      logic [4:0]                      common;
      logic signed [7:0]               lo;
      logic signed [7:0]               hi;
   } scale_setup_type;

   // Directed row: setting to use, operands, and a sum typed in where obvious
   typedef struct packed {
      int                setup_sel;
      logic signed [7:0] a;
      logic signed [7:0] b;
      logic              eot;
      logic              known;
      logic signed [7:0] sum;
   } directed_row_type;

   typedef struct packed {
      logic signed [7:0] sum;
      logic              eot;
   } sum_expect_type;

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{0,  127, -128, 1'b0, 1'b1,    0},  // reset state: all multipliers zero
      '{0, -128,  127, 1'b1, 1'b1,    0},
      '{1,  127,  127, 1'b0, 1'b1,  100},  // output zero point only
      '{1, -128, -128, 1'b1, 1'b1,  100},
      '{2,    0,    0, 1'b0, 1'b1, -128},  // zero point below range
      '{3,    5,   -7, 1'b1, 1'b1,  127},  // zero point above range
      '{4, -128,  127, 1'b0, 1'b1,   50},  // crossed clamp gives clamp_low
      '{5, -128, -128, 1'b1, 1'b0,    0},  // high multiply saturation, sum wraps
      '{5,  127, -128, 1'b0, 1'b0,    0},
      '{5,   -1,    0, 1'b0, 1'b0,    0},
      '{6,  127, -128, 1'b1, 1'b1,    7},  // operand shifts of 32 and more
      '{6,  -57,   99, 1'b0, 1'b1,    7},
      '{7,    1,   -1, 1'b0, 1'b0,    0},  // mixed scaling, zero right shift
      '{7,  127,  127, 1'b0, 1'b0,    0},
      '{7, -128, -128, 1'b1, 1'b0,    0},
      '{7,    0,    0, 1'b0, 1'b0,    0},
      '{7,   85,  -86, 1'b1, 1'b0,    0},
      '{8,  127,  127, 1'b1, 1'b0,    0},  // every setting bit high
      '{8, -128, -128, 1'b0, 1'b0,    0},
      '{8, -128,  127, 1'b1, 1'b0,    0},
      '{8,    0,   -1, 1'b0, 1'b0,    0}
   };

   logic clock;
   logic reset;

   qadd_req_if req_bus ();
   qadd_rsp_if rsp_bus ();
   qadd_csr_if csr_bus ();

   quantized_int8_add i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Shadow copy of the register file
   logic [qadd_pkg::SETTINGS_W-1:0] cfg_first_scale;
   logic [qadd_pkg::SETTINGS_W-1:0] cfg_second_scale;
   logic [qadd_pkg::SETTINGS_W-1:0] cfg_output_scale;
   logic [4:0]                      cfg_common_shift;
   logic signed [7:0]               cfg_clamp_low;
   logic signed [7:0]               cfg_clamp_high;

   sum_expect_type  pending_sums [$];
   scale_setup_type directed_setups [SETUP_COUNT];

   int error_count;
   int sums_checked;
   int requests_sent;
   int tensors_sent;
   int broadcast_tensors;
   int long_stalls_requested;
   int burst_left;
   int cycle_count;

   // ------------------------------------------------------------------
   // Fixed-point model
   // ------------------------------------------------------------------
   function automatic logic signed [31:0] shift_wrap32(
      input logic signed [31:0] v,
      input int unsigned        amt
   );
      logic signed [31:0] res;
      res = (amt >= 32) ? 32'sd0 : (v << amt);
      return res;
   endfunction

   // Saturating rounding doubling high multiply
   function automatic logic signed [31:0] sat_doubling_high_mul(
      input logic signed [31:0] x,
      input logic signed [31:0] y
   );
      longint prod;
      longint bias;
      longint quot;
      if (x == 32'sh8000_0000 && y == 32'sh8000_0000)
         return 32'sh7FFF_FFFF;
      prod = longint'(x) * longint'(y);
      bias = (prod >= 0) ? (longint'(1) << 30) : (longint'(1) - (longint'(1) << 30));
      quot = (prod + bias) / (longint'(1) << 31);
      return quot[31:0];
   endfunction

   // Right shift rounding halves away from zero
   function automatic logic signed [31:0] round_half_away_shr(
      input logic signed [31:0] v,
      input int unsigned        e
   );
      logic [31:0]        mask;
      logic [31:0]        rem;
      logic [31:0]        thr;
      logic signed [31:0] fl;
      mask = (32'd1 << e) - 32'd1;
      rem  = v & mask;
      thr  = (mask >> 1) + ((v < 0) ? 32'd1 : 32'd0);
      fl   = v >>> e;
      return fl + ((rem > thr) ? 32'sd1 : 32'sd0);
   endfunction

   function automatic logic signed [31:0] rescale_operand(
      input logic signed [7:0]               elem,
      input logic [qadd_pkg::SETTINGS_W-1:0] setting
   );
      logic signed [31:0] x;
      logic signed [8:0]  offset;
      logic signed [31:0] mult;
      int unsigned        sh;
      offset = setting[40:32];
      mult   = setting[31:0];
      x      = elem;
      x      = x + offset;
      sh     = int'(cfg_common_shift) + int'(setting[45:41]);
      return round_half_away_shr(sat_doubling_high_mul(shift_wrap32(x, sh), mult),
                                 int'(setting[50:46]));
   endfunction

   function automatic logic signed [7:0] predict_sum(
      input logic signed [7:0] a,
      input logic signed [7:0] b
   );
      logic signed [31:0] total;
      logic signed [31:0] r;
      logic signed [31:0] mult;
      logic signed [8:0]  zero_point;
      mult       = cfg_output_scale[31:0];
      zero_point = cfg_output_scale[40:32];
      total = rescale_operand(a, cfg_first_scale) + rescale_operand(b, cfg_second_scale);
      r = round_half_away_shr(
             sat_doubling_high_mul(shift_wrap32(total, int'(cfg_output_scale[45:41])), mult),
             int'(cfg_output_scale[50:46]));
      r = r + zero_point;
      if (r > cfg_clamp_high)
         r = cfg_clamp_high;
      if (r < cfg_clamp_low)
         r = cfg_clamp_low;
      return r[7:0];
   endfunction

   function automatic logic [qadd_pkg::SETTINGS_W-1:0] pack_scale(
      input logic [31:0] mult,
      input logic [8:0]  zero,
      input logic [4:0]  lsh,
      input logic [4:0]  rsh
   );
      return {rsh, lsh, zero, mult};
   endfunction

   // Random scaling, mostly in a range that keeps results varied
   function automatic logic [qadd_pkg::SETTINGS_W-1:0] random_scale();
      logic [31:0] mult;
      logic [8:0]  zero;
      logic [4:0]  lsh;
      logic [4:0]  rsh;
      mult = $urandom;
      if ($urandom_range(0, 1) == 0)
         mult[31:30] = 2'b01;
      zero = 9'($urandom);
      lsh  = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
      rsh  = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 10));
      return pack_scale(mult, zero, lsh, rsh);
   endfunction

   function automatic scale_setup_type random_setup();
      scale_setup_type s;
      s.first  = random_scale();
      s.second = random_scale();
      s.outs   = random_scale();
      s.common = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(12, 24));
      if ($urandom_range(0, 4) == 0) begin
         s.lo = 8'($urandom);
         s.hi = 8'($urandom);
      end else begin
         s.lo = 8'(-128 + int'($urandom_range(0, 40)));
         s.hi = 8'(127 - int'($urandom_range(0, 40)));
      end
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Reporting
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] MISMATCH %s: got %0d, want %0d (response %0d)",
               $realtime, what, got, want, sums_checked);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Clock and watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[%0t] timeout with %0d responses outstanding", $realtime,
                  pending_sums.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Register writes, only while nothing is in flight
   // ------------------------------------------------------------------
   task automatic write_register(input logic [qadd_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [qadd_pkg::CSR_DATA_W-1:0]  value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         qadd_pkg::REG_FIRST_OPERAND:  cfg_first_scale  = value;
         qadd_pkg::REG_SECOND_OPERAND: cfg_second_scale = value;
         qadd_pkg::REG_OUTPUT:         cfg_output_scale = value;
         qadd_pkg::REG_COMMON_SHIFT:   cfg_common_shift = value[4:0];
         qadd_pkg::REG_CLAMP_LOW:      cfg_clamp_low    = value[7:0];
         qadd_pkg::REG_CLAMP_HIGH:     cfg_clamp_high   = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Narrow registers get random upper bits; one write hits an unmapped index
   task automatic apply_setup(input scale_setup_type s);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_register(qadd_pkg::REG_FIRST_OPERAND, s.first);
      write_register(qadd_pkg::REG_SECOND_OPERAND, s.second);
      write_register(qadd_pkg::REG_OUTPUT, s.outs);
      write_register(qadd_pkg::REG_COMMON_SHIFT, {junk[qadd_pkg::SETTINGS_W-1:5], s.common});
      write_register(qadd_pkg::REG_CLAMP_LOW, {junk[qadd_pkg::SETTINGS_W-1:8], s.lo});
      write_register(qadd_pkg::REG_CLAMP_HIGH, {~junk[qadd_pkg::SETTINGS_W-1:8], s.hi});
      write_register(qadd_pkg::CSR_INDEX_W'($urandom_range(UNMAPPED_FIRST, UNMAPPED_LAST)),
                     junk[qadd_pkg::SETTINGS_W-1:0]);
   endtask

   // ------------------------------------------------------------------
   // Request side: bursts of random length with random gaps
   // ------------------------------------------------------------------
   task automatic send_request(input logic signed [7:0] a,
                               input logic signed [7:0] b,
                               input logic              eot,
                               input logic              known,
                               input logic signed [7:0] known_sum);
      sum_expect_type awaited;
      int             gap;
      @(negedge clock);
      req_bus.valid         = 1'b1;
      req_bus.operand_a     = a;
      req_bus.operand_b     = b;
      req_bus.end_of_tensor = eot;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      awaited.sum = known ? known_sum : predict_sum(a, b);
      awaited.eot = eot;
      pending_sums.push_back(awaited);
      requests_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(20, 60))
                                                  : int'($urandom_range(1, 10));
         gap = int'($urandom_range(1, 6));
         @(negedge clock);
         req_bus.valid         = 1'b0;
         req_bus.operand_a     = 8'($urandom);
         req_bus.operand_b     = 8'($urandom);
         req_bus.end_of_tensor = 1'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stop offering, then wait for every response and a few quiet cycles
   task automatic settle_pipeline();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_sums.size() != 0)
         @(posedge clock);
      repeat (qadd_pkg::PIPE_DEPTH + 3) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: stall pattern, plus long holds on request
   // ------------------------------------------------------------------
   initial begin
      int          slot;
      int          hold_left;
      int          holds_done;
      logic [15:0] pattern;
      slot          = 0;
      hold_left     = 0;
      holds_done    = 0;
      pattern       = '1;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != long_stalls_requested) begin
            hold_left = LONG_STALL_CYCLES;
            holds_done++;
         end
         if (hold_left != 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            if (slot == 0) begin
               case ($urandom_range(0, 3))
                  0: pattern = '1;
                  1: pattern = 16'($urandom);
                  2: pattern = 16'($urandom | $urandom);
                  default: pattern = 16'($urandom & $urandom);
               endcase
            end
            rsp_bus.ready = pattern[slot];
            slot = (slot + 1) % 16;
         end
      end
   end

   // Compare each response with the oldest outstanding sum
   always @(posedge clock) begin
      sum_expect_type due;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_sums.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_bus.sum_out, 0);
         end else begin
            due = pending_sums.pop_front();
            if (rsp_bus.sum_out !== due.sum)
               report_mismatch("sum_out", rsp_bus.sum_out, due.sum);
            if (rsp_bus.end_of_tensor_out !== due.eot)
               report_mismatch("end_of_tensor_out", rsp_bus.end_of_tensor_out, due.eot);
         end
         sums_checked++;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int                cur_setup;
      int                phase_items;
      int                len;
      logic              broadcast;
      logic signed [7:0] scalar;
      logic signed [7:0] b;
      logic              eot;

      requests_sent         = 0;
      tensors_sent          = 0;
      broadcast_tensors     = 0;
      long_stalls_requested = 0;
      burst_left            = 1;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.operand_a     = '0;
      req_bus.operand_b     = '0;
      req_bus.end_of_tensor = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;

      cfg_first_scale  = qadd_pkg::SETTINGS_RESET;
      cfg_second_scale = qadd_pkg::SETTINGS_RESET;
      cfg_output_scale = qadd_pkg::SETTINGS_RESET;
      cfg_common_shift = qadd_pkg::COMMON_SHIFT_RESET;
      cfg_clamp_low    = qadd_pkg::CLAMP_LOW_RESET;
      cfg_clamp_high   = qadd_pkg::CLAMP_HIGH_RESET;

      // Settings used by the directed table
      directed_setups[0] = '{qadd_pkg::SETTINGS_RESET, qadd_pkg::SETTINGS_RESET,
                             qadd_pkg::SETTINGS_RESET, qadd_pkg::COMMON_SHIFT_RESET,
                             qadd_pkg::CLAMP_LOW_RESET, qadd_pkg::CLAMP_HIGH_RESET};
      directed_setups[1] = '{'0, '0, pack_scale(32'd0, 9'd100, 5'd0, 5'd0),
                             5'd20, -8'sd128, 8'sd127};
      directed_setups[2] = '{'0, '0, pack_scale(32'd0, 9'h100, 5'd0, 5'd0),
                             5'd20, -8'sd128, 8'sd127};
      directed_setups[3] = '{'0, '0, pack_scale(32'd0, 9'h0FF, 5'd0, 5'd0),
                             5'd20, -8'sd128, 8'sd127};
      directed_setups[4] = '{'0, '0, '0, 5'd20, 8'sd50, -8'sd50};
      directed_setups[5] = '{pack_scale(32'h8000_0000, 9'd0, 5'd0, 5'd0),
                             pack_scale(32'h8000_0000, 9'd0, 5'd0, 5'd0),
                             pack_scale(32'h4000_0000, 9'd0, 5'd0, 5'd0),
                             5'd24, -8'sd128, 8'sd127};
      directed_setups[6] = '{pack_scale(32'h7FFF_FFFF, 9'h0FF, 5'd1, 5'd3),
                             pack_scale(32'h8000_0000, 9'h100, 5'd31, 5'd31),
                             pack_scale(32'h1234_5678, 9'd7, 5'd5, 5'd2),
                             5'd31, -8'sd128, 8'sd127};
      directed_setups[7] = '{pack_scale(32'h5A5A_5A5A, 9'd127, 5'd3, 5'd5),
                             pack_scale(32'h7FFF_FFFF, 9'h100, 5'd0, 5'd0),
                             pack_scale(32'h6000_0000, 9'h1FD, 5'd2, 5'd7),
                             5'd20, -8'sd100, 8'sd90};
      directed_setups[8] = '{'1, '1, '1, 5'd0, -8'sd128, 8'sd127};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table; the first rows run on reset values
      cur_setup = 0;
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].setup_sel != cur_setup) begin
            settle_pipeline();
            cur_setup = DIRECTED_ROWS[i].setup_sel;
            apply_setup(directed_setups[cur_setup]);
         end
         send_request(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].eot,
                      DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].sum);
      end

      // Random tensors under random settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_pipeline();
         apply_setup(random_setup());
         // long receiver hold while requests keep coming
         if (phase == 1)
            long_stalls_requested++;
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            len       = int'($urandom_range(1, 24));
            broadcast = ($urandom_range(0, 3) == 0);
            scalar    = 8'($urandom);
            for (int k = 0; k < len; k++) begin
               b   = broadcast ? scalar : 8'($urandom);
               eot = (k == len - 1);
               // occasional stray or missing end marker
               if ($urandom_range(0, 11) == 0)
                  eot = 1'($urandom);
               send_request(8'($urandom), b, eot, 1'b0, 8'sd0);
            end
            phase_items += len;
            tensors_sent++;
            if (broadcast)
               broadcast_tensors++;
         end
      end

      settle_pipeline();
      $display("Run covered %0d requests over %0d directed and %0d random settings,",
               requests_sent, SETUP_COUNT, RANDOM_PHASES);
      $display("%0d random tensors (%0d broadcast), %0d responses compared, %0d long stall(s).",
               tensors_sent, broadcast_tensors, sums_checked, long_stalls_requested);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
src/qadd_pkg.sv
src/qadd_req_if.sv
src/qadd_rsp_if.sv
src/qadd_csr_if.sv
src/qadd_rescale.sv
src/quantized_int8_add.sv
src/qadd_checker.sv
tb/quantized_int8_add_tb.sv
